FILE: src/wzs_pkg.sv
// Shared widths and constants for the weighted zone selector.
package wzs_pkg;

	localparam int COUNT_W      = 16;
	localparam int WEIGHT_W     = 16;
	localparam int MASK_W       = 4;
	localparam int ZONE_INDEX_W = 2;
	localparam int CFG_INDEX_W  = 4;
	localparam int DIV_STEP_W   = 4;

	localparam logic [COUNT_W-1:0]    COUNT_MAX    = '1;
	localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET = WEIGHT_W'(1);
	localparam logic [DIV_STEP_W-1:0] DIV_LAST     = DIV_STEP_W'(WEIGHT_W - 1);

endpackage

FILE: src/weighted_zone_selector.sv
// Weighted zone selector: sequential zone scan with one shared restoring divider.
// The scan visits each zone in turn; for each eligible zone with nonzero count it runs a
// divider pass and then a compare state (ST_UPDATE) before moving on.
// An eligible zone with zero count ends the scan early, done following its own scan cycle.
// One word at a time: busy stays high until done; done lasts one cycle, no stall.
// Reset clears all use counts and sets every weight to one.
module weighted_zone_selector #(
	parameter int ZONES = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [wzs_pkg::MASK_W-1:0]          present_mask,
	output logic                                done,
	output logic                                zone_found,
	output logic [wzs_pkg::ZONE_INDEX_W-1:0]    zone_index,
	output logic                                counts_cleared,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wzs_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [wzs_pkg::WEIGHT_W-1:0]        cfg_data
);

	localparam int IDX_W  = (ZONES > 1) ? $clog2(ZONES) : 1;
	localparam int SCAN_W = $clog2(ZONES + 1);
	localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(ZONES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_UPDATE
	} state_t;

	state_t                                state_q;
	logic [wzs_pkg::WEIGHT_W-1:0]          weight_q [ZONES];
	logic [wzs_pkg::COUNT_W-1:0]           count_q  [ZONES];
	logic [wzs_pkg::MASK_W-1:0]            mask_q;
	logic [SCAN_W-1:0]                     scan_q;
	logic                                  have_best_q;
	logic                                  have_least_q;
	logic [IDX_W-1:0]                      best_q;
	logic [IDX_W-1:0]                      least_q;
	logic [wzs_pkg::WEIGHT_W-1:0]          best_quo_q;
	logic [wzs_pkg::WEIGHT_W-1:0]          least_quo_q;
	logic [wzs_pkg::COUNT_W-1:0]           best_cnt_q;
	logic [wzs_pkg::COUNT_W-1:0]           divisor_q;
	logic [wzs_pkg::COUNT_W-1:0]           rem_q;
	logic [wzs_pkg::WEIGHT_W-1:0]          quo_q;
	logic [wzs_pkg::DIV_STEP_W-1:0]        step_q;
	logic                                  done_q;
	logic                                  found_q;
	logic [wzs_pkg::ZONE_INDEX_W-1:0]      index_q;
	logic                                  cleared_q;

	logic [IDX_W-1:0]                      cur_idx;
	logic [wzs_pkg::COUNT_W:0]             shifted;
	logic [wzs_pkg::COUNT_W:0]             trial;
	logic                                  fits;
	logic [wzs_pkg::COUNT_W-1:0]           cur_cnt;

	assign cur_idx = scan_q[IDX_W-1:0];
	assign cur_cnt = count_q[cur_idx];
	assign shifted = {rem_q, quo_q[wzs_pkg::WEIGHT_W-1]};
	assign trial   = shifted - {1'b0, divisor_q};
	assign fits    = !trial[wzs_pkg::COUNT_W];

	assign busy           = (state_q != ST_IDLE);
	assign cfg_ready      = 1'b1;
	assign done           = done_q;
	assign zone_found     = found_q;
	assign zone_index     = index_q;
	assign counts_cleared = cleared_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= 1'b0;
			have_best_q  <= 1'b0;
			have_least_q <= 1'b0;
			for (int i = 0; i < ZONES; i++) begin
				weight_q[i] <= wzs_pkg::WEIGHT_RESET;
				count_q[i]  <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && (cfg_index < wzs_pkg::CFG_INDEX_W'(ZONES))) begin
				weight_q[cfg_index[IDX_W-1:0]] <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						mask_q       <= present_mask;
						scan_q       <= '0;
						have_best_q  <= 1'b0;
						have_least_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_q == SCAN_END) begin
						// finish: bump the best zone unless saturated, clear all when it is also the least
						done_q    <= 1'b1;
						found_q   <= have_best_q;
						index_q   <= have_best_q ? wzs_pkg::ZONE_INDEX_W'(best_q) : '0;
						cleared_q <= have_best_q && have_least_q && (best_q == least_q);
						if (have_best_q && have_least_q && (best_q == least_q)) begin
							for (int i = 0; i < ZONES; i++) begin
								count_q[i] <= '0;
							end
						end else if (have_best_q && (best_cnt_q != wzs_pkg::COUNT_MAX)) begin
							count_q[best_q] <= best_cnt_q + wzs_pkg::COUNT_W'(1);
						end
						state_q <= ST_IDLE;
					end else if (!mask_q[cur_idx]) begin
						scan_q <= scan_q + SCAN_W'(1);
					end else if (cur_cnt == '0) begin
						count_q[cur_idx] <= wzs_pkg::COUNT_W'(1);
						done_q           <= 1'b1;
						found_q          <= 1'b1;
						index_q          <= wzs_pkg::ZONE_INDEX_W'(cur_idx);
						cleared_q        <= 1'b0;
						state_q          <= ST_IDLE;
					end else begin
						divisor_q <= cur_cnt;
						quo_q     <= weight_q[cur_idx];
						rem_q     <= '0;
						step_q    <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= fits ? trial[wzs_pkg::COUNT_W-1:0] : shifted[wzs_pkg::COUNT_W-1:0];
					quo_q  <= {quo_q[wzs_pkg::WEIGHT_W-2:0], fits};
					step_q <= step_q + wzs_pkg::DIV_STEP_W'(1);
					if (step_q == wzs_pkg::DIV_LAST) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (!have_best_q) begin
						have_best_q <= 1'b1;
						best_q      <= cur_idx;
						best_quo_q  <= quo_q;
						best_cnt_q  <= divisor_q;
					end else begin
						if (quo_q > best_quo_q) begin
							best_q     <= cur_idx;
							best_quo_q <= quo_q;
							best_cnt_q <= divisor_q;
						end
						if (!have_least_q || (quo_q < least_quo_q)) begin
							have_least_q <= 1'b1;
							least_q      <= cur_idx;
							least_quo_q  <= quo_q;
						end
					end
					scan_q  <= scan_q + SCAN_W'(1);
					state_q <= ST_SCAN;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
